// ===== hdl/ssfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfr_pkg
// Shared types, constants and the segment decode table for the frame receiver
// ----------------------------------------------------------------------------
package ssfr_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h5A;
  localparam logic [7:0] DASH_PATTERN = 8'h40;
  localparam int unsigned DISPLAY_BIT = 4;
  localparam int unsigned POINT_BIT   = 7;

  localparam logic [2:0] CNT_STATUS   = 3'd3;
  localparam logic [2:0] CNT_CHECK    = 3'd4;

  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [4:0] {
    CH_0     = 5'd0,
    CH_1     = 5'd1,
    CH_2     = 5'd2,
    CH_3     = 5'd3,
    CH_4     = 5'd4,
    CH_5     = 5'd5,
    CH_6     = 5'd6,
    CH_7     = 5'd7,
    CH_8     = 5'd8,
    CH_9     = 5'd9,
    CH_BLANK = 5'd10,
    CH_DASH  = 5'd11,
    CH_A     = 5'd12,
    CH_E     = 5'd13,
    CH_F     = 5'd14,
    CH_H     = 5'd15,
    CH_L     = 5'd16,
    CH_T     = 5'd17,
    CH_R     = 5'd18,
    CH_BAD   = 5'd19
  } char_t;

  // completed frame handed from the parser to the output stage
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] status;
    logic [7:0] seg_left;
    logic [7:0] seg_middle;
    logic [7:0] seg_right;
  } frame_t;

  function automatic char_t seg_decode(input logic [6:0] pattern);
    char_t ch;
    unique case (pattern)
      7'h3f:   ch = CH_0;
      7'h06:   ch = CH_1;
      7'h5b:   ch = CH_2;
      7'h4f:   ch = CH_3;
      7'h66:   ch = CH_4;
      7'h6d:   ch = CH_5;
      7'h7d:   ch = CH_6;
      7'h07:   ch = CH_7;
      7'h7f:   ch = CH_8;
      7'h6f:   ch = CH_9;
      7'h00:   ch = CH_BLANK;
      7'h40:   ch = CH_DASH;
      7'h77:   ch = CH_A;
      7'h79:   ch = CH_E;
      7'h71:   ch = CH_F;
      7'h76:   ch = CH_H;
      7'h38:   ch = CH_L;
      7'h31:   ch = CH_T;
      7'h50:   ch = CH_R;
      default: ch = CH_BAD;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/ssfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// ssfr_in_stage
// Input register for received bytes, drained whenever the pipeline advances
// ----------------------------------------------------------------------------
module ssfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       advance,
  output logic       byte_vld,
  output logic [7:0] byte_data
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_tready = !vld_r || advance;

  always_comb begin
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_vld  = vld_r && advance;
  assign byte_data = byte_r;

endmodule

// ===== hdl/ssfr_parser.sv =====
// ----------------------------------------------------------------------------
// ssfr_parser
// Sync hunt, payload capture and running checksum; flags a frame on its
// checksum byte
// ----------------------------------------------------------------------------
module ssfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_vld,
  input  logic [7:0]      byte_data,
  output ssfr_pkg::frame_t frame
);

  logic       receiving_r;
  logic       receiving_nxt;
  logic [2:0] count_r;
  logic [2:0] count_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] seg_r [3];
  logic [7:0] status_r;
  logic       is_check;

  assign is_check = receiving_r && (count_r >= ssfr_pkg::CNT_CHECK);

  always_comb begin
    receiving_nxt = receiving_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    if (byte_vld) begin
      if (!receiving_r) begin
        if (byte_data == ssfr_pkg::SYNC_BYTE) begin
          receiving_nxt = 1'b1;
          count_nxt     = '0;
          sum_nxt       = '0;
        end
      end else if (is_check) begin
        receiving_nxt = 1'b0;
        count_nxt     = '0;
        sum_nxt       = '0;
      end else begin
        count_nxt = count_r + 3'd1;
        sum_nxt   = sum_r + byte_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
    end else begin
      receiving_r <= receiving_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && receiving_r && (count_r < ssfr_pkg::CNT_STATUS)) begin
      seg_r[count_r[1:0]] <= byte_data;
    end
    if (byte_vld && receiving_r && (count_r == ssfr_pkg::CNT_STATUS)) begin
      status_r <= byte_data;
    end
  end

  always_comb begin
    frame.valid      = byte_vld && is_check;
    frame.ok         = (sum_r == byte_data);
    frame.status     = status_r;
    frame.seg_left   = seg_r[0];
    frame.seg_middle = seg_r[1];
    frame.seg_right  = seg_r[2];
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ssfr_pkg::CNT_CHECK)
    else $error("payload count out of range");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !receiving_r |-> (count_r == 3'd0 && sum_r == 8'd0))
    else $error("idle parser holds stale count or sum");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    frame.valid |=> !receiving_r)
    else $error("parser did not return to idle after a frame");

  a_frame_after_four: assert property (@(posedge clk) disable iff (!rst_n)
    frame.valid |-> count_r == ssfr_pkg::CNT_CHECK)
    else $error("frame emitted before four payload bytes");
`endif

endmodule

// ===== hdl/ssfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// ssfr_out_stage
// Segment decode, point and lock flags, and the result register
// ----------------------------------------------------------------------------
module ssfr_out_stage (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ssfr_pkg::frame_t                       frame,
  output logic                                   advance,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [ssfr_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  logic                              vld_r;
  logic                              vld_nxt;
  logic [ssfr_pkg::OUT_TDATA_W-1:0]  data_r;
  logic [ssfr_pkg::OUT_TDATA_W-1:0]  data_nxt;
  ssfr_pkg::char_t                   ch_left;
  ssfr_pkg::char_t                   ch_middle;
  ssfr_pkg::char_t                   ch_right;
  logic [2:0]                        points;
  logic                              disp;
  logic                              locked;

  assign advance = !vld_r || out_tready;

  always_comb begin
    ch_left   = ssfr_pkg::seg_decode(frame.seg_left[6:0]);
    ch_middle = ssfr_pkg::seg_decode(frame.seg_middle[6:0]);
    ch_right  = ssfr_pkg::seg_decode(frame.seg_right[6:0]);
    points    = {frame.seg_right[ssfr_pkg::POINT_BIT],
                 frame.seg_middle[ssfr_pkg::POINT_BIT],
                 frame.seg_left[ssfr_pkg::POINT_BIT]};
    disp      = frame.status[ssfr_pkg::DISPLAY_BIT];
    locked    = frame.ok && disp &&
                (frame.seg_left == ssfr_pkg::DASH_PATTERN) &&
                (frame.seg_middle == ssfr_pkg::DASH_PATTERN) &&
                (frame.seg_right == ssfr_pkg::DASH_PATTERN);
    data_nxt  = {3'b000, locked, points, ch_right, ch_middle, ch_left,
                 frame.status, disp, frame.ok};
  end

  always_comb begin
    if (frame.valid) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

endmodule

// ===== hdl/seven_segment_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_frame_receiver
// A checksum byte passes through the input register and then the result register
// Throughput: one byte per cycle unless a stalled result holds the pipeline,
// set by the single-pass parse and decode between the input register and the result register
// Reset: rst_n low returns the parser to sync hunt and empties both registers
// ----------------------------------------------------------------------------
module seven_segment_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_ok[0], display_on[1], status_byte[9:2], char_left[14:10],
  // char_middle[19:15], char_right[24:20], points[27:25],
  // screen_locked[28], zero[31:29]
  output logic [31:0] out_tdata
);

  logic             advance;
  logic             byte_vld;
  logic [7:0]       byte_data;
  ssfr_pkg::frame_t frame;

  ssfr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .byte_vld  (byte_vld),
    .byte_data (byte_data)
  );

  ssfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .byte_data (byte_data),
    .frame     (frame)
  );

  ssfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame      (frame),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_lock_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |-> (out_tdata[0] && out_tdata[1]))
    else $error("lock flagged without a good frame and lit display");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    frame.valid |=> out_tvalid)
    else $error("finished frame did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !frame.valid)
    else $error("frame would overwrite a stalled result");
`endif

endmodule
